// File: rtl/optimal_parse_lz_compressor_macros.svh
// Assertion helpers for the block's top-level RTL file.
`ifndef OPTIMAL_PARSE_LZ_COMPRESSOR_MACROS_SVH
`define OPTIMAL_PARSE_LZ_COMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OPLZ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OPLZ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/oplz_pkg.sv
`timescale 1ns / 1ps
package oplz_pkg;

  localparam int BLOCK_SIZE_DEF = 1024;
  localparam int MAX_RUN_DEF    = 128;
  localparam int WINDOW_DEF     = 256;
  localparam int INIT_BIAS      = 128;
  localparam logic [7:0] MATCH_FLAG = 8'h80;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_COMPRESS = 2'd1,
    MODE_READ     = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_PAST = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_P0, ST_P1, ST_L0, ST_L1, ST_L2, ST_ADV,
    ST_TSTART, ST_TFIRST, ST_TNODE, ST_TDEC, ST_TMATCH, ST_TLRD, ST_TLWR
  } state_t;

  // Control for the distance window row.
  typedef struct packed {
    logic arm;      // load working history from base line, set alive flags
    logic step;     // compare with current byte and shift working history
    logic advance;  // shift the base line by one position
  } win_ctrl_t;

endpackage

// File: rtl/oplz_cell.sv
`timescale 1ns / 1ps
module oplz_cell
  import oplz_pkg::*;
#(
  parameter int IDX = 1,
  parameter int DW  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  win_ctrl_t     ctrl,
  input  logic [DW-1:0] dmax,
  input  logic [7:0]    cur,
  input  logic [7:0]    base_in,
  input  logic [7:0]    hist_in,
  output logic [7:0]    base_out,
  output logic [7:0]    hist_out,
  output logic          alive
);

  logic [7:0] base;
  logic [7:0] hist;

  // base holds the byte IDX places before the current position,
  // hist the byte IDX places before the byte under comparison.
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      base <= base_in;
    end
    if (ctrl.arm) begin
      hist <= base;
    end else if (ctrl.step) begin
      hist <= hist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (ctrl.arm) begin
      alive <= (DW'(IDX) <= dmax);
    end else if (ctrl.step) begin
      alive <= alive && (hist == cur);
    end
  end

  assign base_out = base;
  assign hist_out = hist;

endmodule

// File: rtl/oplz_window.sv
`timescale 1ns / 1ps
module oplz_window
  import oplz_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int DW     = $clog2(WINDOW)
) (
  input  logic          clk,
  input  logic          rst,
  input  win_ctrl_t     ctrl,
  input  logic [DW-1:0] dmax,
  input  logic [7:0]    cur,
  input  logic [7:0]    byte_in,
  output logic          any_alive,
  output logic [DW-1:0] first_dist
);

  logic [7:0]        base_c [WINDOW];
  logic [7:0]        hist_c [WINDOW];
  logic [WINDOW-1:0] alive_v;

  assign base_c[0]  = byte_in;
  assign hist_c[0]  = cur;
  assign alive_v[0] = 1'b0;

  for (genvar d = 1; d < WINDOW; d++) begin : g_cell
    oplz_cell #(.IDX(d), .DW(DW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .dmax     (dmax),
      .cur      (cur),
      .base_in  (base_c[d-1]),
      .hist_in  (hist_c[d-1]),
      .base_out (base_c[d]),
      .hist_out (hist_c[d]),
      .alive    (alive_v[d])
    );
  end

  assign any_alive = |alive_v;

  // Nearest live distance wins among equal-cost matches.
  always_comb begin
    first_dist = '0;
    for (int d = WINDOW - 1; d >= 1; d--) begin
      if (alive_v[d]) begin
        first_dist = DW'(d);
      end
    end
  end

endmodule

// File: rtl/optimal_parse_lz_compressor.sv
`timescale 1ns / 1ps
// Optimal-parse LZ compressor. Load beats (tuser mode 0) append a byte to the
// block store while it has room and read beats (mode 2) return the next
// compressed byte; both stream back to back through the output register while
// the output is not stalled. A compress beat (mode 1) runs a node clearing
// pass, then a least-cost search that steps through each position and each length
// tried, each length step comparing every window distance at once in a row
// of WINDOW-1 history cells, then a trace back that writes the output bytes;
// its result beat appears when the stream is in the output store.
module optimal_parse_lz_compressor
  import oplz_pkg::*;
#(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
  parameter int MAX_RUN    = MAX_RUN_DEF,
  parameter int WINDOW     = WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [19:8] compressed_length, zero pad
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

`include "optimal_parse_lz_compressor_macros.svh"

  localparam int OUT_CAP = 2 * BLOCK_SIZE + INIT_BIAS;
  localparam int PW  = $clog2(BLOCK_SIZE + 1);
  localparam int AW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int CW  = $clog2(2 * BLOCK_SIZE + INIT_BIAS + 1);
  localparam int LW  = $clog2(MAX_RUN);
  localparam int DW  = $clog2(WINDOW);
  localparam int OW  = $clog2(OUT_CAP + 1);
  localparam int OAW = $clog2(OUT_CAP);

  // Memories.
  logic [7:0]    blk_mem [BLOCK_SIZE];
  logic [CW-1:0] nc_mem  [BLOCK_SIZE + 1];
  logic [LW-1:0] nl_mem  [BLOCK_SIZE + 1];
  logic [DW-1:0] ns_mem  [BLOCK_SIZE + 1];
  logic [7:0]    out_mem [OUT_CAP];

  logic          blk_we, blk_re;
  logic [AW-1:0] blk_waddr, blk_raddr;
  logic [7:0]    blk_q;
  logic          node_we, node_re;
  logic [PW-1:0] node_waddr, node_raddr;
  logic [CW-1:0] node_wcost, nc_q;
  logic [LW-1:0] node_wlen, nl_q;
  logic [DW-1:0] node_wsrc, ns_q;
  logic          om_we, om_re;
  logic [OAW-1:0] om_waddr, om_raddr;
  logic [7:0]    om_wd, om_q;

  // Control and datapath registers.
  state_t        state, state_next;
  logic [PW-1:0] loaded_count, n, p, pos, init_i;
  logic [LW-1:0] len, tr_len, k;
  logic [CW-1:0] here, best_cost, tr_w;
  logic [DW-1:0] best_src, tr_src, dmax;
  logic          upd;
  logic [7:0]    byte_p;
  logic [OW-1:0] compressed_total, read_index;
  logic          pend, pend_rd;
  logic          pend_last;
  status_t       pend_status;

  win_ctrl_t     wctrl;
  logic          any_alive;
  logic [DW-1:0] first_dist;

  logic          acc, move;
  mode_t         in_mode;
  logic [PW-1:0] tgt;
  logic [CW:0]   c_lit, c_match;
  logic          stop_here, match_wins, read_ok;
  logic [CW-1:0] init_cost;

  assign in_mode   = mode_t'(s_tuser);
  assign move      = pend && (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_tready  = (state == ST_IDLE) && (!pend || move);
  assign acc       = s_tvalid && s_tready;
  assign read_ok   = read_index < compressed_total;
  assign tgt       = p + PW'(len);
  assign c_lit     = {1'b0, here} + (CW+1)'(len) + (CW+1)'(1);
  assign c_match   = {1'b0, here} + (CW+1)'(2);
  assign stop_here = nc_q <= here;
  assign match_wins = any_alive && (c_match < {1'b0, best_cost});
  assign init_cost = CW'({n, 1'b0}) + CW'(INIT_BIAS);
  assign dmax      = (32'(p) < WINDOW - 1) ? DW'(p) : DW'(WINDOW - 1);

  oplz_window #(.WINDOW(WINDOW), .DW(DW)) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (wctrl),
    .dmax       (dmax),
    .cur        (blk_q),
    .byte_in    (byte_p),
    .any_alive  (any_alive),
    .first_dist (first_dist)
  );

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= s_tdata;
    end
    if (blk_re) begin
      blk_q <= blk_mem[blk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      nc_mem[node_waddr] <= node_wcost;
      nl_mem[node_waddr] <= node_wlen;
      ns_mem[node_waddr] <= node_wsrc;
    end
    if (node_re) begin
      nc_q <= nc_mem[node_raddr];
      nl_q <= nl_mem[node_raddr];
      ns_q <= ns_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (om_we) begin
      out_mem[om_waddr] <= om_wd;
    end
    if (om_re) begin
      om_q <= out_mem[om_raddr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (acc && in_mode == MODE_COMPRESS) state_next = ST_INIT;
      ST_INIT:   if (init_i == n) state_next = ST_P0;
      ST_P0:     state_next = ST_P1;
      ST_P1:     state_next = ST_L0;
      ST_L0:     state_next = (tgt <= n) ? ST_L1 : ST_ADV;
      ST_L1:     state_next = stop_here ? ST_ADV : ST_L2;
      ST_L2:     state_next = (32'(len) == MAX_RUN - 1) ? ST_ADV : ST_L0;
      ST_ADV:    state_next = (p == n) ? ST_TSTART : ST_P0;
      ST_TSTART: state_next = ST_TFIRST;
      ST_TFIRST: state_next = ST_TNODE;
      ST_TNODE:  state_next = (pos == '0) ? ST_IDLE : ST_TDEC;
      ST_TDEC:   state_next = (ns_q == '0) ? ST_TLRD : ST_TMATCH;
      ST_TMATCH: state_next = ST_TNODE;
      ST_TLRD:   state_next = ST_TLWR;
      ST_TLWR:   state_next = (k == tr_len - LW'(1)) ? ST_TNODE : ST_TLRD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory and window controls.
  always_comb begin
    blk_we     = 1'b0;
    blk_waddr  = loaded_count[AW-1:0];
    blk_re     = 1'b0;
    blk_raddr  = p[AW-1:0];
    node_we    = 1'b0;
    node_waddr = init_i;
    node_wcost = (init_i == '0) ? '0 : init_cost;
    node_wlen  = '0;
    node_wsrc  = '0;
    node_re    = 1'b0;
    node_raddr = p;
    om_we      = 1'b0;
    om_waddr   = OAW'(nc_q);
    om_wd      = '0;
    om_re      = 1'b0;
    om_raddr   = read_index[OAW-1:0];
    wctrl      = '0;
    unique case (state)
      ST_IDLE: begin
        blk_we = acc && (in_mode == MODE_LOAD) && (32'(loaded_count) < BLOCK_SIZE);
        om_re  = acc && (in_mode == MODE_READ) && read_ok;
      end
      ST_INIT: node_we = 1'b1;
      ST_P0: begin
        node_re = 1'b1;
        blk_re  = 1'b1;
      end
      ST_P1: wctrl.arm = 1'b1;
      ST_L0: begin
        node_re    = tgt <= n;
        node_raddr = tgt;
        blk_re     = tgt <= n;
        blk_raddr  = AW'(tgt - PW'(1));
      end
      ST_L1: wctrl.step = !stop_here;
      ST_L2: begin
        node_we    = upd || match_wins;
        node_waddr = tgt;
        node_wcost = match_wins ? c_match[CW-1:0] : best_cost;
        node_wlen  = len;
        node_wsrc  = match_wins ? first_dist : best_src;
      end
      ST_ADV: wctrl.advance = 1'b1;
      ST_TSTART: begin
        node_re    = 1'b1;
        node_raddr = n;
      end
      ST_TFIRST: om_we = 1'b1;
      ST_TNODE: begin
        node_re    = pos != '0;
        node_raddr = pos;
      end
      ST_TDEC: begin
        om_we = 1'b1;
        if (ns_q == '0) begin
          om_waddr = OAW'(nc_q - CW'(nl_q) - CW'(1));
          om_wd    = 8'(nl_q);
        end else begin
          om_waddr = OAW'(nc_q - CW'(2));
          om_wd    = MATCH_FLAG | 8'(nl_q);
        end
      end
      ST_TMATCH: begin
        om_we    = 1'b1;
        om_waddr = OAW'(tr_w - CW'(1));
        om_wd    = 8'(tr_src);
      end
      ST_TLRD: begin
        blk_re    = 1'b1;
        blk_raddr = AW'(pos - PW'(tr_len) + PW'(k));
      end
      ST_TLWR: begin
        om_we    = 1'b1;
        om_waddr = OAW'(tr_w - CW'(tr_len) + CW'(k));
        om_wd    = blk_q;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      loaded_count     <= '0;
      compressed_total <= '0;
      read_index       <= '0;
      pend             <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (move && !acc) begin
        pend <= 1'b0;
      end
      if (acc) begin
        pend <= 1'b1;
        unique case (in_mode)
          MODE_LOAD: begin
            if (32'(loaded_count) < BLOCK_SIZE) begin
              loaded_count <= loaded_count + PW'(1);
            end
          end
          MODE_COMPRESS: begin
            loaded_count <= '0;
            read_index   <= '0;
          end
          MODE_READ: begin
            if (read_ok) begin
              read_index <= read_index + OW'(1);
            end
          end
          default: ;
        endcase
      end
      if (state == ST_TFIRST) begin
        compressed_total <= OW'(nc_q) + OW'(1);
      end
    end
  end

  // Result beat fields and search datapath.
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_rd     <= (in_mode == MODE_READ) && read_ok;
      pend_last   <= (in_mode == MODE_READ) && read_ok
                     && (read_index + OW'(1) == compressed_total);
      pend_status <= STATUS_OK;
      if (in_mode == MODE_LOAD && 32'(loaded_count) >= BLOCK_SIZE) begin
        pend_status <= STATUS_FULL;
      end
      if (in_mode == MODE_READ && !read_ok) begin
        pend_status <= STATUS_PAST;
      end
      if (in_mode == MODE_COMPRESS) begin
        n      <= loaded_count;
        init_i <= '0;
      end
    end
    if (move) begin
      m_tdata <= {4'd0, 12'(compressed_total), pend_rd ? om_q : 8'd0};
      m_tuser <= pend_status;
      m_tlast <= pend_last;
    end
    case (state)
      ST_INIT: begin
        init_i <= init_i + PW'(1);
        p      <= '0;
      end
      ST_P1: begin
        here   <= nc_q;
        byte_p <= blk_q;
        len    <= LW'(1);
      end
      ST_L1: begin
        if (c_lit < {1'b0, nc_q}) begin
          best_cost <= c_lit[CW-1:0];
          best_src  <= '0;
          upd       <= 1'b1;
        end else begin
          best_cost <= nc_q;
          best_src  <= '0;
          upd       <= 1'b0;
        end
      end
      ST_L2: len <= len + LW'(1);
      ST_ADV: begin
        p   <= p + PW'(1);
        pos <= n;
      end
      ST_TDEC: begin
        tr_w   <= nc_q;
        tr_len <= nl_q;
        tr_src <= ns_q;
        k      <= '0;
        if (ns_q != '0) begin
          pos <= pos - PW'(nl_q);
        end
      end
      ST_TLWR: begin
        k <= k + LW'(1);
        if (k == tr_len - LW'(1)) begin
          pos <= pos - PW'(tr_len);
        end
      end
      default: ;
    endcase
  end

  `OPLZ_ASSERT_NEXT(a_compress_starts, acc && in_mode == MODE_COMPRESS, state == ST_INIT, "compress beat did not start the clearing pass")
  `OPLZ_ASSERT(a_last_is_ok, m_tvalid && m_tlast, m_tuser == STATUS_OK, "final byte flagged with an error status")
  `OPLZ_ASSERT(a_past_end_zero, m_tvalid && m_tuser == STATUS_PAST, m_tdata[7:0] == 8'd0 && !m_tlast, "read past end returned data")

endmodule
